>>> sv/alarm_frame_builder_crc16_top_defines.svh
// ----------------------------------------------------------------------------
// Alarm frame builder assertion macros
// Shared property forms for the frame checker, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef ALARM_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH
`define ALARM_FRAME_BUILDER_CRC16_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFB_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame builder check failed");

// Consequent must hold in the cycle after the antecedent.
`define AFB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame builder check failed");

`endif

>>> sv/afb_pkg.sv
// ----------------------------------------------------------------------------
// Alarm frame builder package
// Frame constants, pipeline word type and the bytewise CRC-16 update.
// ----------------------------------------------------------------------------
package afb_pkg;

    localparam int FRAME_LEN = 7;
    localparam int CRC_SPAN  = 5;
    localparam int MSG_BITS  = 8 * CRC_SPAN;
    localparam int FRAME_BITS = 8 * FRAME_LEN;
    localparam logic [2:0] LAST_IDX = 3'(FRAME_LEN - 1);

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    typedef struct packed {
        logic [7:0]  cmd;
        logic [31:0] diff;
        logic [15:0] crc;
    } afb_word_t;

    // One message byte through the CRC register, MSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] acc,
                                               input logic [7:0]  octet);
        logic [15:0] c;
        c = acc ^ {octet, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if ((c & CRC_TOP) != 16'h0000)
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

>>> sv/afb_crc_stage.sv
// ----------------------------------------------------------------------------
// Alarm frame builder CRC stage
// One pipeline register that folds one message byte into the running CRC.
// ----------------------------------------------------------------------------
module afb_crc_stage
    import afb_pkg::*;
#(
    parameter int BYTE_IDX = 0
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  afb_word_t in_word,
    output logic      in_ready,
    output logic      out_valid,
    output afb_word_t out_word,
    input  logic      out_ready
);

    logic                valid_reg;
    afb_word_t           word_reg;
    afb_word_t           word_next;
    logic [MSG_BITS-1:0] msg;
    logic [7:0]          octet;

    assign msg   = {in_word.cmd, in_word.diff};
    assign octet = msg[MSG_BITS - 1 - 8 * BYTE_IDX -: 8];

    always_comb
    begin
        word_next     = in_word;
        word_next.crc = crc16_byte(in_word.crc, octet);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            word_reg <= word_next;
    end

endmodule

>>> sv/afb_serializer.sv
// ----------------------------------------------------------------------------
// Alarm frame builder serializer
// Holds one finished frame and shifts it out one byte per cycle.
// ----------------------------------------------------------------------------
module afb_serializer
    import afb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  afb_word_t in_word,
    output logic      in_ready,
    output logic      strobe,
    output logic [7:0] frame_byte,
    output logic      last_byte
);

    logic                  active_reg;
    logic                  active_next;
    logic [2:0]            idx_reg;
    logic [2:0]            idx_next;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] frame_next;
    logic                  load;

    // A new frame may enter in the same cycle the last byte goes out.
    assign in_ready = !active_reg || (idx_reg == LAST_IDX);
    assign load     = in_valid && in_ready;

    always_comb
    begin
        active_next = active_reg;
        idx_next    = idx_reg;
        frame_next  = frame_reg;
        if (load)
        begin
            active_next = 1'b1;
            idx_next    = 3'd0;
            frame_next  = {in_word.cmd, in_word.diff, in_word.crc};
        end
        else if (active_reg)
        begin
            if (idx_reg == LAST_IDX)
                active_next = 1'b0;
            idx_next   = idx_reg + 3'd1;
            frame_next = {frame_reg[FRAME_BITS-9:0], 8'h00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= 3'd0;
        end
        else
        begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    assign strobe     = active_reg;
    assign frame_byte = frame_reg[FRAME_BITS-1 -: 8];
    assign last_byte  = active_reg && (idx_reg == LAST_IDX);

endmodule

>>> sv/alarm_frame_builder_crc16_top.sv
// A start transaction passes the difference register, the CRC stages and the serializer, in that order.
// The byte serializer at the output sets the frame rate: it loads a new frame as the last byte goes out.
// Up to six transactions are buffered in the pipeline; busy rises when it is full.
// Reset clears all valid bits and the serializer; no byte is strobed until a start.
// ----------------------------------------------------------------------------
// Alarm frame builder top level
// Subtracts the times, runs a five-stage CRC-16 pipeline and serializes the frame.
// ----------------------------------------------------------------------------
module alarm_frame_builder_crc16_top
    import afb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  command_code,
    input  logic [31:0] target_time,
    input  logic [31:0] current_time,
    output logic        strobe,
    output logic [7:0]  frame_byte,
    output logic        last_byte
);

    logic      diff_valid_reg;
    afb_word_t diff_word_reg;
    logic      diff_ready;
    logic      accept;

    logic      stg_valid [CRC_SPAN+1];
    afb_word_t stg_word  [CRC_SPAN+1];
    logic      stg_ready [CRC_SPAN+1];

    assign diff_ready = !diff_valid_reg || stg_ready[0];
    assign busy       = !diff_ready;
    assign accept     = start && diff_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            diff_valid_reg <= 1'b0;
        else if (diff_ready)
            diff_valid_reg <= start;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            diff_word_reg.cmd  <= command_code;
            diff_word_reg.diff <= target_time - current_time;
            diff_word_reg.crc  <= CRC_INIT;
        end
    end

    assign stg_valid[0] = diff_valid_reg;
    assign stg_word[0]  = diff_word_reg;

    for (genvar k = 0; k < CRC_SPAN; k++)
    begin : g_crc
        afb_crc_stage #(
            .BYTE_IDX (k)
        ) u_crc_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[k]),
            .in_word   (stg_word[k]),
            .in_ready  (stg_ready[k]),
            .out_valid (stg_valid[k+1]),
            .out_word  (stg_word[k+1]),
            .out_ready (stg_ready[k+1])
        );
    end

    afb_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (stg_valid[CRC_SPAN]),
        .in_word    (stg_word[CRC_SPAN]),
        .in_ready   (stg_ready[CRC_SPAN]),
        .strobe     (strobe),
        .frame_byte (frame_byte),
        .last_byte  (last_byte)
    );

endmodule

>>> sv/afb_checker.sv
// ----------------------------------------------------------------------------
// Alarm frame builder checker
// Watches the result port for complete, contiguous seven-byte frames.
// ----------------------------------------------------------------------------
`include "alarm_frame_builder_crc16_top_defines.svh"

module afb_checker
(
    input logic clk,
    input logic rst_n,
    input logic strobe,
    input logic last_byte
);

    // The final byte of a frame is always a strobed byte.
    `AFB_ASSERT_SAME(a_last_strobed, last_byte, strobe)
    // Bytes of one frame come out without gaps.
    `AFB_ASSERT_NEXT(a_no_gap, strobe && !last_byte, strobe)
    // A frame is seven bytes, so the six before the last were strobed too.
    `AFB_ASSERT_SAME(a_frame_length, last_byte, $past(strobe, 6) && !$past(last_byte, 6))
    // The byte stream only stops at the end of a frame.
    `AFB_ASSERT_SAME(a_stop_at_end, $fell(strobe), $past(last_byte))

endmodule

bind alarm_frame_builder_crc16_top afb_checker u_afb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .strobe    (strobe),
    .last_byte (last_byte)
);
